[rtl/krbp_pkg.sv]
// shared types and codes for the range block parser
package krbp_pkg;

   localparam logic [7:0] PAD_BYTE = 8'hFF;

   localparam logic [2:0] PH_HEADER    = 3'd0;
   localparam logic [2:0] PH_BEGIN_LEN = 3'd1;
   localparam logic [2:0] PH_BEGIN_DAT = 3'd2;
   localparam logic [2:0] PH_KEY_LEN   = 3'd3;
   localparam logic [2:0] PH_KEY_DAT   = 3'd4;
   localparam logic [2:0] PH_VAL_LEN   = 3'd5;
   localparam logic [2:0] PH_VAL_DAT   = 3'd6;
   localparam logic [2:0] PH_PAD       = 3'd7;

   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_KEY   = 2'd1;
   localparam logic [1:0] KIND_VALUE = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_VERSION = 2'd1;
   localparam logic [1:0] ST_CORRUPT = 2'd2;
   localparam logic [1:0] ST_PADDING = 2'd3;

   typedef struct packed {
      logic [2:0]  phase;
      logic [1:0]  prefix_count;
      logic [31:0] length_shift;
      logic [31:0] bytes_remaining;
      logic [1:0]  error_code;
   } krbp_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       is_empty;
      logic       field_last;
      logic       block_done;
      logic [1:0] status;
   } krbp_result_type;

   localparam krbp_state_type STATE_CLEAR = '{
      phase:           PH_HEADER,
      prefix_count:    2'd0,
      length_shift:    32'd0,
      bytes_remaining: 32'd0,
      error_code:      ST_OK
   };

endpackage

[rtl/kv_range_block_parser.sv]
// range block parser top level: state registers, result register and skid stage
//
//   channel  dir  handshake               payload
//   req      in   req_tvalid/req_tready   tdata in_byte, tlast in_last
//   rsp      out  rsp_tvalid/rsp_tready   tdata data_byte/field_last/status,
//                                          tuser kind/is_empty, tlast block_done
//   csr      in   csr_valid/csr_ready     csr_data expected_version
//
// one request per cycle while the skid entry is empty; each result is registered
// the parse state updates in the accept cycle, so there is no per-byte loop
// synchronous reset returns to the header phase with version register zero
// a result register plus one skid entry keep requests flowing while rsp stalls
// req_tready drops only while the skid entry is full
module kv_range_block_parser import krbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [8] field_last, [10:9] status, zero
   output logic [2:0]  rsp_tuser,   // [1:0] kind, [2] is_empty
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic [31:0]     version_ff;
   krbp_state_type  state_ff;
   krbp_state_type  state_in;
   logic            out_valid_ff;
   logic            out_valid_in;
   krbp_result_type out_ff;
   krbp_result_type out_in;
   logic            skid_valid_ff;
   logic            skid_valid_in;
   krbp_result_type skid_ff;
   krbp_result_type skid_in;

   logic            accept;
   logic            step_emit;
   logic            new_valid;
   krbp_result_type step_result;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   krbp_step u_step (
      .state            (state_ff),
      .in_byte          (req_tdata),
      .in_last          (req_tlast),
      .expected_version (version_ff),
      .state_next       (state_in),
      .emit             (step_emit),
      .result           (step_result)
   );

   assign new_valid = accept && step_emit;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = new_valid;
            out_in       = step_result;
         end
      end else if (new_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff    <= 32'd0;
         state_ff      <= STATE_CLEAR;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            version_ff <= csr_data;
         end
         if (accept) begin
            state_ff <= state_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.status, out_ff.field_last, out_ff.data_byte};
   assign rsp_tuser  = {out_ff.is_empty, out_ff.kind};
   assign rsp_tlast  = out_ff.block_done;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while result register empty");

   a_rearm_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (state_ff.phase == PH_HEADER && state_ff.error_code == ST_OK))
      else $error("parser not rearmed after block end");

   a_no_data_after_error: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tlast && state_ff.error_code != ST_OK) |-> !step_emit)
      else $error("data emitted after sticky error");

   a_status_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (new_valid && !step_result.block_done) |-> (step_result.status == ST_OK))
      else $error("status set on a result without block end");

endmodule

[rtl/krbp_step.sv]
// next-state and result logic for one block byte
module krbp_step import krbp_pkg::*; (
   input  krbp_state_type  state,
   input  logic [7:0]      in_byte,
   input  logic            in_last,
   input  logic [31:0]     expected_version,
   output krbp_state_type  state_next,
   output logic            emit,
   output krbp_result_type result
);

   logic [31:0] shifted_len;
   logic [31:0] header_word;
   logic [31:0] remaining_dec;
   logic [1:0]  len_kind;
   logic        do_len;
   logic        at_end;
   logic        data_emit;
   krbp_state_type upd;

   assign shifted_len   = {state.length_shift[23:0], in_byte};
   assign header_word   = state.length_shift | ({24'd0, in_byte} << {state.prefix_count, 3'b000});
   assign remaining_dec = state.bytes_remaining - 32'd1;

   always_comb begin
      upd       = state;
      data_emit = 1'b0;
      do_len    = 1'b0;
      result    = '{kind: KIND_NONE, data_byte: 8'd0, is_empty: 1'b0, field_last: 1'b0,
                    block_done: 1'b0, status: ST_OK};
      case (state.phase)
         PH_BEGIN_LEN: len_kind = KIND_BEGIN;
         PH_KEY_LEN:   len_kind = KIND_KEY;
         default:      len_kind = KIND_VALUE;
      endcase

      if (state.error_code == ST_OK) begin
         case (state.phase)
            PH_HEADER: begin
               if (state.prefix_count == 2'd3) begin
                  upd.prefix_count = 2'd0;
                  upd.length_shift = 32'd0;
                  if (header_word != expected_version) begin
                     upd.error_code = ST_VERSION;
                  end else begin
                     upd.phase = PH_BEGIN_LEN;
                  end
               end else begin
                  upd.length_shift = header_word;
                  upd.prefix_count = state.prefix_count + 2'd1;
               end
            end
            PH_KEY_LEN, PH_VAL_LEN: begin
               if (state.prefix_count == 2'd0 && in_byte == PAD_BYTE) begin
                  upd.phase = PH_PAD;
               end else begin
                  do_len = 1'b1;
               end
            end
            PH_BEGIN_LEN: begin
               do_len = 1'b1;
            end
            PH_BEGIN_DAT, PH_KEY_DAT, PH_VAL_DAT: begin
               data_emit            = 1'b1;
               result.kind          = (state.phase == PH_BEGIN_DAT) ? KIND_BEGIN :
                                      (state.phase == PH_KEY_DAT) ? KIND_KEY : KIND_VALUE;
               result.data_byte     = in_byte;
               upd.bytes_remaining  = remaining_dec;
               if (remaining_dec == 32'd0) begin
                  result.field_last = 1'b1;
                  upd.phase = (state.phase == PH_KEY_DAT) ? PH_VAL_LEN : PH_KEY_LEN;
               end
            end
            default: begin
               if (in_byte != PAD_BYTE) begin
                  upd.error_code = ST_PADDING;
               end
            end
         endcase

         if (do_len) begin
            if (state.prefix_count == 2'd3) begin
               upd.prefix_count    = 2'd0;
               upd.bytes_remaining = shifted_len;
               upd.length_shift    = 32'd0;
               if (shifted_len == 32'd0) begin
                  data_emit         = 1'b1;
                  result.kind       = len_kind;
                  result.is_empty   = 1'b1;
                  result.field_last = 1'b1;
                  upd.phase = (len_kind == KIND_KEY) ? PH_VAL_LEN : PH_KEY_LEN;
               end else begin
                  upd.phase = (len_kind == KIND_BEGIN) ? PH_BEGIN_DAT :
                              (len_kind == KIND_KEY) ? PH_KEY_DAT : PH_VAL_DAT;
               end
            end else begin
               upd.length_shift = shifted_len;
               upd.prefix_count = state.prefix_count + 2'd1;
            end
         end
      end

      at_end = (upd.phase == PH_PAD) ||
               ((upd.phase inside {PH_KEY_LEN, PH_VAL_LEN}) && upd.prefix_count == 2'd0);

      if (in_last) begin
         if (upd.error_code == ST_OK && !at_end) begin
            upd.error_code = ST_CORRUPT;
         end
         if (upd.error_code != ST_OK) begin
            result.kind       = KIND_NONE;
            result.data_byte  = 8'd0;
            result.is_empty   = 1'b0;
            result.field_last = 1'b0;
         end
         result.block_done = 1'b1;
         result.status     = upd.error_code;
         emit              = 1'b1;
         state_next        = STATE_CLEAR;
      end else begin
         emit       = data_emit && (upd.error_code == ST_OK);
         state_next = upd;
      end
   end

endmodule

[test/tb_kv_range_block_parser.sv]
// testbench for the range block parser: directed and random blocks against a local parse model
`timescale 1ns / 100ps

module tb_kv_range_block_parser import krbp_pkg::*;;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] in_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [7:0] data_byte, [8] field_last, [10:9] status, zero
   logic [2:0]  rsp_tuser;          // [1:0] kind, [2] is_empty
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = 32'd0;

   // local parse state
   logic [2:0]  parse_phase = PH_HEADER;
   logic [1:0]  prefix_cnt = 2'd0;
   logic [31:0] word_acc = 32'd0;
   logic [31:0] field_remain = 32'd0;
   logic [1:0]  block_error = ST_OK;
   logic [31:0] version_reg = 32'd0;

   krbp_result_type pending_results[$];
   logic [7:0]      blk[$];
   int              mismatches = 0;
   int              bytes_sent = 0;
   logic            no_idle = 1'b0;
   int              rsp_stall = 0;

   kv_range_block_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task automatic clear_parse();
      parse_phase = PH_HEADER;
      prefix_cnt = 2'd0;
      word_acc = 32'd0;
      field_remain = 32'd0;
      block_error = ST_OK;
   endtask

   // advance the parse model by one accepted byte and queue any result
   task automatic parse_byte(input logic [7:0] b, input logic last);
      krbp_result_type r;
      logic            emit;
      logic [1:0]      k;
      r = '0;
      r.kind = KIND_NONE;
      emit = 1'b0;
      if (block_error == ST_OK) begin
         case (parse_phase)
            PH_HEADER: begin
               word_acc = word_acc | ({24'd0, b} << (8 * prefix_cnt));
               if (prefix_cnt == 2'd3) begin
                  prefix_cnt = 2'd0;
                  if (word_acc != version_reg) block_error = ST_VERSION;
                  else parse_phase = PH_BEGIN_LEN;
                  word_acc = 32'd0;
               end else begin
                  prefix_cnt++;
               end
            end
            PH_BEGIN_LEN, PH_KEY_LEN, PH_VAL_LEN: begin
               if (parse_phase != PH_BEGIN_LEN && prefix_cnt == 2'd0 && b == PAD_BYTE) begin
                  parse_phase = PH_PAD;
               end else begin
                  word_acc = {word_acc[23:0], b};
                  if (prefix_cnt == 2'd3) begin
                     k = (parse_phase == PH_BEGIN_LEN) ? KIND_BEGIN :
                         (parse_phase == PH_KEY_LEN) ? KIND_KEY : KIND_VALUE;
                     prefix_cnt = 2'd0;
                     field_remain = word_acc;
                     word_acc = 32'd0;
                     if (field_remain == 32'd0) begin
                        emit = 1'b1;
                        r.kind = k;
                        r.is_empty = 1'b1;
                        r.field_last = 1'b1;
                        parse_phase = (k == KIND_KEY) ? PH_VAL_LEN : PH_KEY_LEN;
                     end else begin
                        parse_phase = (k == KIND_BEGIN) ? PH_BEGIN_DAT :
                                      (k == KIND_KEY) ? PH_KEY_DAT : PH_VAL_DAT;
                     end
                  end else begin
                     prefix_cnt++;
                  end
               end
            end
            PH_BEGIN_DAT, PH_KEY_DAT, PH_VAL_DAT: begin
               emit = 1'b1;
               r.kind = (parse_phase == PH_BEGIN_DAT) ? KIND_BEGIN :
                        (parse_phase == PH_KEY_DAT) ? KIND_KEY : KIND_VALUE;
               r.data_byte = b;
               field_remain--;
               if (field_remain == 32'd0) begin
                  r.field_last = 1'b1;
                  parse_phase = (r.kind == KIND_KEY) ? PH_VAL_LEN : PH_KEY_LEN;
               end
            end
            default: begin
               if (b != PAD_BYTE) block_error = ST_PADDING;
            end
         endcase
      end
      if (last) begin
         if (block_error == ST_OK && !(parse_phase == PH_PAD ||
             ((parse_phase == PH_KEY_LEN || parse_phase == PH_VAL_LEN) && prefix_cnt == 2'd0)))
            block_error = ST_CORRUPT;
         if (block_error != ST_OK) begin
            r = '0;
            r.kind = KIND_NONE;
         end
         r.block_done = 1'b1;
         r.status = block_error;
         pending_results = {pending_results, r};
         clear_parse();
      end else if (emit && block_error == ST_OK) begin
         pending_results = {pending_results, r};
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_byte(b, last);
   endtask

   task automatic send_block();
      for (int i = 0; i < blk.size(); i++)
         send_byte(blk[i], i == blk.size() - 1);
      bytes_sent += blk.size();
   endtask

   // hold off requests until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_version(input logic [31:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      version_reg = v;
   endtask

   task automatic add_field(input logic [31:0] len);
      for (int i = 3; i >= 0; i--) blk = {blk, len[8*i +: 8]};
      for (int i = 0; i < len && i < 6; i++) blk = {blk, 8'($urandom_range(0, 255))};
   endtask

   function automatic logic [31:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 32'd0;
      if (r < 96) return $urandom_range(1, 6);
      return $urandom();
   endfunction

   task automatic build_block(input logic [31:0] ver);
      int n_rec;
      int ending;
      int n;
      blk.delete();
      if ($urandom_range(0, 99) < 4) ver = ver ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) blk = {blk, ver[8*i +: 8]};
      add_field(pick_len());
      n_rec = $urandom_range(0, 4);
      for (int i = 0; i < n_rec; i++) begin
         add_field(pick_len());
         add_field(pick_len());
      end
      ending = $urandom_range(0, 3);
      if (ending == 0 || ending == 3) add_field(pick_len());
      if (ending <= 1) begin
         n = (ending == 1) ? $urandom_range(1, 4) : $urandom_range(0, 3);
         repeat (n) blk = {blk, PAD_BYTE};
      end
      if ($urandom_range(0, 99) < 8) begin
         n = $urandom_range(1, blk.size());
         while (blk.size() > n) void'(blk.pop_back());
      end
      if ($urandom_range(0, 99) < 6)
         blk[$urandom_range(0, blk.size() - 1)] = 8'($urandom_range(0, 255));
   endtask

   task automatic test_version_check();
      blk = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_block();
      blk = '{8'h01, 8'h00, 8'h00, 8'h00};
      send_block();
      // version error must win over the truncation that follows
      blk = '{8'h00, 8'h00, 8'h80, 8'h00, 8'h00};
      send_block();
   endtask

   task automatic test_truncation();
      blk = '{8'h00, 8'h00};
      send_block();
      blk = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_block();
      blk = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h11, 8'h22};
      send_block();
   endtask

   task automatic test_full_records();
      write_version(32'hFFFF_FFFF);
      no_idle = 1'b1;
      blk = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h02, 8'hAB, 8'hCD,
              8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF,
              8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'hFF, 8'hFF};
      send_block();
      no_idle = 1'b0;
      // empty begin key, empty key, empty value ending the block
      blk = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_block();
   endtask

   task automatic test_bad_padding();
      blk = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF};
      send_block();
   endtask

   task automatic test_random_blocks();
      logic [31:0] ver;
      int          phase_end;
      for (int p = 0; p < 7; p++) begin
         ver = (p == 1) ? 32'hFFFF_FFFF : (p == 3) ? 32'h0000_0000 : $urandom();
         write_version(ver);
         phase_end = bytes_sent + 215;
         while (bytes_sent < phase_end) begin
            no_idle = ($urandom_range(0, 99) < 15);
            build_block(ver);
            send_block();
         end
         no_idle = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   always @(posedge clock) begin : check_results
      krbp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no request pending");
         end else begin
            want = pending_results.pop_front();
            check_field("kind", {6'd0, rsp_tuser[1:0]}, {6'd0, want.kind});
            check_field("data_byte", rsp_tdata[7:0], want.data_byte);
            check_field("is_empty", {7'd0, rsp_tuser[2]}, {7'd0, want.is_empty});
            check_field("field_last", {7'd0, rsp_tdata[8]}, {7'd0, want.field_last});
            check_field("block_done", {7'd0, rsp_tlast}, {7'd0, want.block_done});
            check_field("status", {6'd0, rsp_tdata[10:9]}, {6'd0, want.status});
            check_field("tdata fill", {3'd0, rsp_tdata[15:11]}, 8'd0);
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_version_check();
      test_truncation();
      test_full_records();
      test_bad_padding();
      test_random_blocks();
      req_tvalid <= 1'b0;
      for (int guard = 0; guard < 5000 && pending_results.size() != 0; guard++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("timeout at %0t", $realtime);
      $display("== FAIL ==");
      $finish;
   end

endmodule

[files.f]
rtl/krbp_pkg.sv
rtl/krbp_step.sv
rtl/kv_range_block_parser.sv
test/tb_kv_range_block_parser.sv
